### design/lsdr_pkg.sv
package lsdr_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CAP_W = 7;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned RDEPTH_W = 7;
  localparam int unsigned STAT_W = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 3'd0,
    FN_POP    = 3'd1,
    FN_PEEK   = 3'd2,
    FN_DUP    = 3'd3,
    FN_ROT_UP = 3'd4,
    FN_ROT_DN = 3'd5,
    FN_PRINT  = 3'd6
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_DEPTH = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHIFT_DN,
    OP_SHIFT_UP,
    OP_ROT_UP,
    OP_ROT_DN
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  k;
    logic [BYTE_W-1:0] ins;
  } cmd_t;

endpackage

### design/lsdr_cell.sv
module lsdr_cell (
  input  logic                          clk_i,
  input  logic [lsdr_pkg::IDX_W-1:0]    idx_i,
  input  lsdr_pkg::cmd_t                cmd_i,
  input  logic [lsdr_pkg::BYTE_W-1:0]   prev_i,
  input  logic [lsdr_pkg::BYTE_W-1:0]   next_i,
  input  logic [lsdr_pkg::BYTE_W-1:0]   top_i,
  output logic [lsdr_pkg::BYTE_W-1:0]   q_o
);

  logic [lsdr_pkg::BYTE_W-1:0] val_q, val_d;
  logic                        is_top;

  assign is_top = (idx_i == '0);

  always_comb begin
    val_d = val_q;
    unique case (cmd_i.op)
      lsdr_pkg::OP_SHIFT_DN: val_d = is_top ? cmd_i.ins : prev_i;
      lsdr_pkg::OP_SHIFT_UP: val_d = next_i;
      lsdr_pkg::OP_ROT_UP: begin
        if (idx_i < cmd_i.k) begin
          val_d = next_i;
        end else if (idx_i == cmd_i.k) begin
          val_d = top_i;
        end
      end
      lsdr_pkg::OP_ROT_DN: begin
        if (is_top) begin
          val_d = cmd_i.ins;
        end else if (idx_i <= cmd_i.k) begin
          val_d = prev_i;
        end
      end
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign q_o = val_q;

endmodule

### design/lsdr_ctrl.sv
module lsdr_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lsdr_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [2*lsdr_pkg::BYTE_W-1:0]   s_axis_tdata,
  input  logic [lsdr_pkg::FUNC_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lsdr_pkg::BYTE_W-1:0]     m_axis_tdata,
  output logic [lsdr_pkg::STAT_W-1:0]     m_axis_tuser,
  output logic                            m_axis_tlast,
  input  logic [lsdr_pkg::BYTE_W-1:0]     top_i,
  input  logic [lsdr_pkg::BYTE_W-1:0]     sel_i,
  output lsdr_pkg::cmd_t                  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_PRINT
  } state_e;

  state_e                          state_q, state_d;
  logic [lsdr_pkg::CNT_W-1:0]      fill_q, fill_d;
  logic [lsdr_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [lsdr_pkg::CAP_W-1:0]      cap_q;
  logic                            ovld_q, ovld_d;
  logic [lsdr_pkg::STAT_W-1:0]     stat_q, stat_d;
  logic [lsdr_pkg::BYTE_W-1:0]     data_q, data_d;
  logic                            last_q, last_d;

  logic [lsdr_pkg::CAP_W-1:0]      eff_cap;
  logic                            at_limit;
  logic                            empty;
  logic                            out_free;
  logic                            acc;
  logic [lsdr_pkg::BYTE_W-1:0]     in_value;
  logic [lsdr_pkg::RDEPTH_W-1:0]   in_rdepth;
  logic [lsdr_pkg::RDEPTH_W-1:0]   rd_m1;
  logic [lsdr_pkg::CNT_W-1:0]      fill_m1;

  assign eff_cap   = (cap_q < lsdr_pkg::CAP_W'(lsdr_pkg::DEPTH)) ? cap_q
                   : lsdr_pkg::CAP_W'(lsdr_pkg::DEPTH);
  assign at_limit  = ({1'b0, fill_q} >= {1'b0, eff_cap});
  assign empty     = (fill_q == '0);
  assign out_free  = !ovld_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign acc       = s_axis_tvalid && s_axis_tready;
  assign in_value  = s_axis_tdata[lsdr_pkg::BYTE_W-1:0];
  assign in_rdepth = s_axis_tdata[lsdr_pkg::BYTE_W +: lsdr_pkg::RDEPTH_W];
  assign rd_m1     = in_rdepth - lsdr_pkg::RDEPTH_W'(1);
  assign fill_m1   = fill_q - lsdr_pkg::CNT_W'(1);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q && !m_axis_tready;
    stat_d  = stat_q;
    data_d  = data_q;
    last_d  = last_q;
    cmd_o   = '{op: lsdr_pkg::OP_HOLD, k: '0, ins: '0};
    if (acc) begin
      unique case (lsdr_pkg::func_e'(s_axis_tuser))
        lsdr_pkg::FN_PUSH: begin
          ovld_d = 1'b1;
          data_d = '0;
          last_d = 1'b1;
          if (at_limit) begin
            stat_d = lsdr_pkg::STAT_FULL;
          end else begin
            stat_d = lsdr_pkg::STAT_OK;
            cmd_o  = '{op: lsdr_pkg::OP_SHIFT_DN, k: '0, ins: in_value};
            fill_d = fill_q + lsdr_pkg::CNT_W'(1);
          end
        end
        lsdr_pkg::FN_POP: begin
          ovld_d = 1'b1;
          last_d = 1'b1;
          if (empty) begin
            stat_d = lsdr_pkg::STAT_EMPTY;
            data_d = '0;
          end else begin
            stat_d = lsdr_pkg::STAT_OK;
            data_d = top_i;
            cmd_o  = '{op: lsdr_pkg::OP_SHIFT_UP, k: '0, ins: '0};
            fill_d = fill_m1;
          end
        end
        lsdr_pkg::FN_PEEK: begin
          ovld_d = 1'b1;
          last_d = 1'b1;
          stat_d = empty ? lsdr_pkg::STAT_EMPTY : lsdr_pkg::STAT_OK;
          data_d = empty ? '0 : top_i;
        end
        lsdr_pkg::FN_DUP: begin
          ovld_d = 1'b1;
          data_d = '0;
          last_d = 1'b1;
          if (empty) begin
            stat_d = lsdr_pkg::STAT_EMPTY;
          end else if (at_limit) begin
            stat_d = lsdr_pkg::STAT_FULL;
          end else begin
            stat_d = lsdr_pkg::STAT_OK;
            cmd_o  = '{op: lsdr_pkg::OP_SHIFT_DN, k: '0, ins: top_i};
            fill_d = fill_q + lsdr_pkg::CNT_W'(1);
          end
        end
        lsdr_pkg::FN_ROT_UP, lsdr_pkg::FN_ROT_DN: begin
          ovld_d = 1'b1;
          data_d = '0;
          last_d = 1'b1;
          if ({1'b0, in_rdepth} > {1'b0, fill_q}) begin
            stat_d = lsdr_pkg::STAT_DEPTH;
          end else begin
            stat_d = lsdr_pkg::STAT_OK;
            if (in_rdepth >= lsdr_pkg::RDEPTH_W'(2)) begin
              cmd_o.k = rd_m1[lsdr_pkg::IDX_W-1:0];
              if (lsdr_pkg::func_e'(s_axis_tuser) == lsdr_pkg::FN_ROT_UP) begin
                cmd_o.op = lsdr_pkg::OP_ROT_UP;
              end else begin
                cmd_o.op  = lsdr_pkg::OP_ROT_DN;
                cmd_o.ins = sel_i;
              end
            end
          end
        end
        lsdr_pkg::FN_PRINT: begin
          if (empty) begin
            ovld_d = 1'b1;
            stat_d = lsdr_pkg::STAT_EMPTY;
            data_d = '0;
            last_d = 1'b1;
          end else begin
            state_d = S_PRINT;
            cnt_d   = fill_q;
          end
        end
        default: state_d = state_q;
      endcase
    end else if (state_q == S_PRINT && out_free) begin
      ovld_d = 1'b1;
      stat_d = lsdr_pkg::STAT_OK;
      data_d = top_i;
      last_d = (cnt_q == lsdr_pkg::CNT_W'(1));
      cmd_o  = '{op: lsdr_pkg::OP_ROT_UP, k: fill_m1[lsdr_pkg::IDX_W-1:0], ins: '0};
      cnt_d  = cnt_q - lsdr_pkg::CNT_W'(1);
      if (cnt_q == lsdr_pkg::CNT_W'(1)) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      cap_q   <= lsdr_pkg::CAP_RESET;
      ovld_q  <= 1'b0;
      stat_q  <= '0;
      data_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      stat_q  <= stat_d;
      data_q  <= data_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = stat_q;
  assign m_axis_tlast  = last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= lsdr_pkg::CNT_W'(lsdr_pkg::DEPTH))
    else $error("fill count beyond depth");

  a_print_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PRINT |-> cnt_q != '0 && cnt_q <= fill_q)
    else $error("print count out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tuser == lsdr_pkg::FN_PUSH && !at_limit
    |=> fill_q == $past(fill_q) + lsdr_pkg::CNT_W'(1))
    else $error("push did not grow the stack");

  a_print_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PRINT && out_free && cnt_q == lsdr_pkg::CNT_W'(1)
    |=> state_q == S_IDLE && m_axis_tvalid && m_axis_tlast)
    else $error("print did not close with a last beat");

endmodule

### design/lifo_stack_dup_rotate_unit.sv
// Byte stack of up to 64 entries held in a row of shifting cells, top entry in
// the first cell. Push, pop, peek, duplicate and both rotations take one beat
// in and give one beat out, one item per cycle while the output is taken.
// Print moves the whole stack around the row one place per cycle while the
// output is taken and gives one beat per stored entry (one empty-status beat
// when empty); no new item is taken until its last beat is loaded. The single
// output register decides the pace: a stalled output holds the input off.
// The user writes capacity via cfg_we_i only while idle; the block does not enforce it.
module lifo_stack_dup_rotate_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsdr_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [2*lsdr_pkg::BYTE_W-1:0] s_axis_tdata,  // value[7:0], rotate_depth[14:8]
  input  logic [lsdr_pkg::FUNC_W-1:0]   s_axis_tuser,  // func[2:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lsdr_pkg::BYTE_W-1:0]   m_axis_tdata,  // data[7:0]
  output logic [lsdr_pkg::STAT_W-1:0]   m_axis_tuser,  // status[1:0]
  output logic                          m_axis_tlast
);

  lsdr_pkg::cmd_t              cmd;
  logic [lsdr_pkg::BYTE_W-1:0] cell_q [lsdr_pkg::DEPTH];
  logic [lsdr_pkg::BYTE_W-1:0] sel;

  assign sel = cell_q[cmd.k];

  lsdr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .top_i         (cell_q[0]),
    .sel_i         (sel),
    .cmd_o         (cmd)
  );

  for (genvar g = 0; g < lsdr_pkg::DEPTH; g++) begin : g_cell
    logic [lsdr_pkg::BYTE_W-1:0] prev, nxt;
    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = cell_q[g-1];
    end
    if (g == lsdr_pkg::DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_body
      assign nxt = cell_q[g+1];
    end
    lsdr_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (lsdr_pkg::IDX_W'(g)),
      .cmd_i  (cmd),
      .prev_i (prev),
      .next_i (nxt),
      .top_i  (cell_q[0]),
      .q_o    (cell_q[g])
    );
  end

endmodule
